/* hw/rtl/imp_pkg.sv */
// shared types, constants and helpers for the isotropic metric point evaluator
// no dependencies
package imp_pkg;

    localparam int RootSteps    = 32;
    localparam int URadDivSteps = 24;
    localparam int LapseDivSteps = 31;

    localparam logic [31:0] RadiusMinRaw = 32'd6554;
    localparam logic [24:0] OneQ16       = 25'd65536;
    localparam logic [20:0] MassReset    = 21'd65536;

    // register byte addresses
    localparam logic [2:0] AddrMass        = 3'd0;
    localparam logic [2:0] AddrLapseOffset = 3'd4;

    // sideband that travels along with each item
    typedef struct packed {
        logic        valid;
        logic        clamped;
        logic [47:0] metric;
    } side_t;

    // one digit of the integer square root
    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } root_t;

    // one quotient bit of restoring division
    typedef struct packed {
        logic [31:0] num;
        logic [33:0] rem;
        logic [31:0] quo;
        logic [33:0] divisor;
    } div_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

/* hw/rtl/isotropic_metric_point_eval_top.sv */
// 128 register stages between the input transfer and the result
// throughput: one point per cycle while the result is not stalled; each root and divider stage is its own cell
// a stalled result freezes the whole chain, input ready follows the result side
// reset (aresetn low, synchronous) clears all valid bits; mass resets to 1.0, offset to 0
// depends on imp_pkg, imp_root_cell, imp_div_cell
module isotropic_metric_point_eval_top
    import imp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_coord_x,
    input  logic [31:0] s_coord_y,
    input  logic [31:0] s_coord_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_diag_metric,
    output logic [17:0] m_lapse,
    output logic        m_radius_clamped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        en;
    logic [20:0] mass_reg;
    logic [18:0] offset_reg;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg   <= MassReset;
            offset_reg <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == AddrLapseOffset[2]) begin
                offset_reg <= pwdata[18:0];
            end else begin
                mass_reg <= pwdata[20:0];
            end
        end
    end
    assign prdata = (paddr[2] == AddrMass[2]) ? {11'd0, mass_reg} : {13'd0, offset_reg};

    side_t out_side_reg;
    assign en      = !out_side_reg.valid || m_ready;
    assign s_ready = en;

    // squares, then their sum
    side_t       sq_side_reg, sum_side_reg, in_side;
    logic [63:0] sqx_reg, sqy_reg, sqz_reg, sum_reg;

    always_comb begin
        in_side         = '0;
        in_side.valid   = s_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_side_reg.valid  <= 1'b0;
            sum_side_reg.valid <= 1'b0;
        end else if (en) begin
            sq_side_reg  <= in_side;
            sum_side_reg <= sq_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= 64'(mag32(s_coord_x)) * 64'(mag32(s_coord_x));
            sqy_reg <= 64'(mag32(s_coord_y)) * 64'(mag32(s_coord_y));
            sqz_reg <= 64'(mag32(s_coord_z)) * 64'(mag32(s_coord_z));
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
        end
    end

    // radius root chain
    side_t rs [0:RootSteps];
    root_t rd [0:RootSteps];
    assign rs[0]      = sum_side_reg;
    assign rd[0].rad  = sum_reg;
    assign rd[0].rem  = '0;
    assign rd[0].root = '0;

    for (genvar i = 0; i < RootSteps; i++) begin : g_radius
        imp_root_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .side_in (rs[i]),
            .data_in (rd[i]),
            .side_out(rs[i+1]),
            .data_out(rd[i+1])
        );
    end

    // radius floor
    side_t       clamp_side_reg;
    side_t       clamp_side_next;
    logic [33:0] twor_reg;
    always_comb begin
        clamp_side_next         = rs[RootSteps];
        clamp_side_next.clamped = (rd[RootSteps].root < RadiusMinRaw);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clamp_side_reg.valid <= 1'b0;
        end else if (en) begin
            clamp_side_reg <= clamp_side_next;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            if (rd[RootSteps].root < RadiusMinRaw) begin
                twor_reg <= {1'b0, RadiusMinRaw, 1'b0};
            end else begin
                twor_reg <= {1'b0, rd[RootSteps].root, 1'b0};
            end
        end
    end

    // u = m * 2^16 / (2r), quotient below 2^24
    side_t us [0:URadDivSteps];
    div_t  ud [0:URadDivSteps];
    assign us[0]         = clamp_side_reg;
    assign ud[0].num     = {mass_reg[7:0], 24'd0};
    assign ud[0].rem     = 34'(mass_reg[20:8]);
    assign ud[0].quo     = '0;
    assign ud[0].divisor = twor_reg;

    for (genvar i = 0; i < URadDivSteps; i++) begin : g_udiv
        imp_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .side_in (us[i]),
            .data_in (ud[i]),
            .side_out(us[i+1]),
            .data_out(ud[i+1])
        );
    end

    // p, |1-u|, then p^2 and p^4
    logic [23:0] u_val;
    side_t       p1_side_reg, p2_side_reg, p3_side_reg;
    side_t       p3_side_next;
    logic [24:0] p1_reg, p2p_reg, p3p_reg;
    logic [23:0] d1_reg, d2_reg, d3_reg;
    logic [33:0] p2_reg;
    logic [49:0] pp_prod;
    logic [67:0] p4_prod;

    assign u_val   = ud[URadDivSteps].quo[23:0];
    assign pp_prod = 50'(p1_reg) * 50'(p1_reg);
    assign p4_prod = 68'(p2_reg) * 68'(p2_reg);

    always_comb begin
        p3_side_next = p2_side_reg;
        // fourth power saturates to all ones
        if (p4_prod[67:64] != 4'd0) begin
            p3_side_next.metric = '1;
        end else begin
            p3_side_next.metric = p4_prod[63:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_side_reg.valid <= 1'b0;
            p2_side_reg.valid <= 1'b0;
            p3_side_reg.valid <= 1'b0;
        end else if (en) begin
            p1_side_reg <= us[URadDivSteps];
            p2_side_reg <= p1_side_reg;
            p3_side_reg <= p3_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg <= OneQ16 + 25'(u_val);
            if (25'(u_val) <= OneQ16) begin
                d1_reg <= 24'(OneQ16 - 25'(u_val));
            end else begin
                d1_reg <= 24'(25'(u_val) - OneQ16);
            end
            p2_reg  <= pp_prod[49:16];
            p2p_reg <= p1_reg;
            d2_reg  <= d1_reg;
            p3p_reg <= p2p_reg;
            d3_reg  <= d2_reg;
        end
    end

    // q = d * 2^30 / p, at most 2^30
    side_t qs [0:LapseDivSteps];
    div_t  qd [0:LapseDivSteps];
    assign qs[0]         = p3_side_reg;
    assign qd[0].num     = {d3_reg[0], 31'd0};
    assign qd[0].rem     = 34'(d3_reg[23:1]);
    assign qd[0].quo     = '0;
    assign qd[0].divisor = 34'(p3p_reg);

    for (genvar i = 0; i < LapseDivSteps; i++) begin : g_qdiv
        imp_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .side_in (qs[i]),
            .data_in (qd[i]),
            .side_out(qs[i+1]),
            .data_out(qd[i+1])
        );
    end

    // q^2 + a, then the lapse root
    side_t       qq_side_reg, v_side_reg;
    logic [61:0] qq_reg;
    logic [63:0] v_reg;
    logic [30:0] q_val;
    assign q_val = qd[LapseDivSteps].quo[30:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qq_side_reg.valid <= 1'b0;
            v_side_reg.valid  <= 1'b0;
        end else if (en) begin
            qq_side_reg <= qs[LapseDivSteps];
            v_side_reg  <= qq_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qq_reg <= 62'(q_val) * 62'(q_val);
            v_reg  <= 64'(qq_reg) + {1'b0, offset_reg, 44'd0};
        end
    end

    side_t ls [0:RootSteps];
    root_t ld [0:RootSteps];
    assign ls[0]      = v_side_reg;
    assign ld[0].rad  = v_reg;
    assign ld[0].rem  = '0;
    assign ld[0].root = '0;

    for (genvar i = 0; i < RootSteps; i++) begin : g_lapse
        imp_root_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .side_in (ls[i]),
            .data_in (ld[i]),
            .side_out(ls[i+1]),
            .data_out(ld[i+1])
        );
    end

    // output register
    logic [17:0] lapse_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_side_reg.valid <= 1'b0;
        end else if (en) begin
            out_side_reg <= ls[RootSteps];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            lapse_reg <= ld[RootSteps].root[31:14];
        end
    end

    assign m_valid          = out_side_reg.valid;
    assign m_diag_metric    = out_side_reg.metric;
    assign m_radius_clamped = out_side_reg.clamped;
    assign m_lapse          = lapse_reg;

    // conformal factor is never below one
    a_metric_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_diag_metric >= 48'd65536))
        else $error("diag_metric below 1.0");

    // with zero mass the factor is exactly one
    a_zero_mass: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (mass_reg == 21'd0)) |-> (m_diag_metric == 48'd65536))
        else $error("zero mass gives wrong metric");

    // lapse bounded by sqrt(1 + largest offset)
    a_lapse_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lapse <= 18'h30000))
        else $error("lapse out of range");

endmodule

/* hw/rtl/imp_root_cell.sv */
// one cell of the square root chain: retires one result bit per cycle while en is high
// depends on imp_pkg
module imp_root_cell
    import imp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  side_t side_in,
    input  root_t data_in,
    output side_t side_out,
    output root_t data_out
);

    side_t side_reg;
    root_t data_reg;
    root_t data_next;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    always_comb begin
        rem_sh = {data_in.rem, data_in.rad[63:62]};
        trial  = {2'b00, data_in.root, 2'b01};
        data_next.rad = {data_in.rad[61:0], 2'b00};
        if (rem_sh >= trial) begin
            data_next.rem  = 34'(rem_sh - trial);
            data_next.root = {data_in.root[30:0], 1'b1};
        end else begin
            data_next.rem  = rem_sh[33:0];
            data_next.root = {data_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign side_out = side_reg;
    assign data_out = data_reg;

endmodule

/* hw/rtl/imp_div_cell.sv */
// one cell of a restoring divider chain: one quotient bit per cycle while en is high
// depends on imp_pkg
module imp_div_cell
    import imp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  side_t side_in,
    input  div_t  data_in,
    output side_t side_out,
    output div_t  data_out
);

    side_t side_reg;
    div_t  data_reg;
    div_t  data_next;
    logic [34:0] rem_sh;

    always_comb begin
        rem_sh = {data_in.rem, data_in.num[31]};
        data_next.num     = {data_in.num[30:0], 1'b0};
        data_next.divisor = data_in.divisor;
        if (rem_sh >= {1'b0, data_in.divisor}) begin
            data_next.rem = 34'(rem_sh - {1'b0, data_in.divisor});
            data_next.quo = {data_in.quo[30:0], 1'b1};
        end else begin
            data_next.rem = rem_sh[33:0];
            data_next.quo = {data_in.quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign side_out = side_reg;
    assign data_out = data_reg;

endmodule
